/* sv/bpa_pkg.sv */
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared codes, constants and types of the bit-packed array store.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

    // Item kinds
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COUNT = 2'd1;
    localparam logic [1:0] ST_CAP   = 2'd2;

    // Marker returned by a failed read
    localparam logic [63:0] BAD_READ = 64'hdead_beef_dead_beef;

    // Element width register reset value
    localparam logic [6:0] WIDTH_RESET = 7'd32;

    // One result item
    typedef struct packed {
        logic [63:0] read_value;
        logic [1:0]  status;
    } bpa_result_t;

endpackage

`default_nettype wire

/* sv/bit_packed_array_store_core.sv */
// ----------------------------------------------------------------------------
// bit_packed_array_store_core
// Densely packed store of 1..64-bit elements in 64-bit words, with read,
// write, whole-store clear and a written-count high-water mark.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------
//  input    | in_valid / in_stall   | mode, index, value
//  result   | out_valid / out_stall | read_value, status
//  config   | cfg_valid / cfg_ready | cfg_data (element width)
//
// A read or write passes through CHECK, WORD0 and, when the element straddles
// two words, WORD1: the memory is read and written word by word. An index
// past capacity or past the written count on a read, and mode three, skip
// the memory. A clear sweeps the memory one word a cycle.
// Reset clears the count, sets the width register to WIDTH_RESET and leaves
// memory contents undefined. Results wait in an output register; the store
// stalls input until its current result has moved into that register.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_packed_array_store_core #(
    parameter int STORE_WORDS = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] index,
    input  wire logic [63:0] value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      read_value,
    output logic [1:0]       status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data
);
    import bpa_pkg::*;

    logic [6:0]  width_reg;
    logic [6:0]  width_eff;
    logic        item_ready;
    logic        res_valid;
    logic        res_ready;
    bpa_result_t res;

    assign cfg_ready = 1'b1;
    assign in_stall  = !item_ready;

    // Clamp width to 1..64
    always_comb
    begin
        if (width_reg == 7'd0)
            width_eff = 7'd1;
        else if (width_reg > 7'd64)
            width_eff = 7'd64;
        else
            width_eff = width_reg;
    end

    // Element width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= WIDTH_RESET;
        else if (cfg_valid && cfg_ready)
            width_reg <= cfg_data;
    end

    bpa_store #(
        .STORE_WORDS (STORE_WORDS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid),
        .item_ready (item_ready),
        .item_mode  (mode),
        .item_index (index),
        .item_value (value),
        .elem_width (width_eff),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    bpa_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .status     (status)
    );

endmodule

`default_nettype wire

/* sv/bpa_store.sv */
// ----------------------------------------------------------------------------
// bpa_store
// Packed word memory with its read-modify-write sequencer, element count and
// clear sweep. Produces one result per accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_store #(
    parameter int STORE_WORDS = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic [1:0]         item_mode,
    input  wire logic [31:0]        item_index,
    input  wire logic [63:0]        item_value,
    input  wire logic [6:0]         elem_width,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output bpa_pkg::bpa_result_t    res
);
    import bpa_pkg::*;

    localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int CW = $clog2(STORE_WORDS * 64 + 1);
    localparam int PW = 39;
    localparam logic [PW:0] TOTAL_BITS = (PW + 1)'(STORE_WORDS) << 6;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WORD0 = 3'd2;
    localparam logic [2:0] S_WORD1 = 3'd3;
    localparam logic [2:0] S_CLEAR = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [1:0]      mode_reg;
    logic [31:0]     idx_reg;
    logic [63:0]     val_reg;
    logic [6:0]      w_reg;
    logic [PW-1:0]   pos_reg;
    logic [63:0]     w0_reg;
    bpa_result_t     res_reg, res_next;

    logic [63:0]     mem [STORE_WORDS];
    logic [63:0]     rdata_reg;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [63:0]     mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;

    logic            accept;
    logic [PW:0]     end_bits;
    logic            over_cap;
    logic            over_count;
    logic [AW-1:0]   word_idx;
    logic [AW-1:0]   word_idx_hi;
    logic [5:0]      bit_off;
    logic            straddle;
    logic [63:0]     elem_mask;
    logic [127:0]    pair;
    logic [127:0]    merged;
    logic [127:0]    shifted;
    logic [63:0]     elem_read;

    assign accept     = item_valid && item_ready;
    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res        = res_reg;

    // Element position and range checks
    assign end_bits    = {1'b0, pos_reg} + (PW + 1)'(w_reg);
    assign over_cap    = (end_bits > TOTAL_BITS);
    assign over_count  = (idx_reg >= 32'(count_reg));
    assign word_idx    = pos_reg[AW+5:6];
    assign word_idx_hi = word_idx + AW'(1);
    assign bit_off     = pos_reg[5:0];
    assign straddle    = ({2'b00, bit_off} + {1'b0, w_reg}) > 8'd64;
    assign elem_mask   = {64{1'b1}} >> (7'd64 - w_reg);

    // Merge and extract over the word pair
    assign pair      = (state_reg == S_WORD1) ? {rdata_reg, w0_reg} : {64'd0, rdata_reg};
    assign merged    = (pair & ~({64'd0, elem_mask} << bit_off))
                     | ({64'd0, val_reg & elem_mask} << bit_off);
    assign shifted   = pair >> bit_off;
    assign elem_read = shifted[63:0] & elem_mask;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        clr_addr_next = clr_addr_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_waddr     = word_idx;
        mem_wdata     = merged[63:0];
        mem_re        = 1'b0;
        mem_raddr     = word_idx;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                res_next.read_value = 64'd0;
                res_next.status     = ST_OK;
                if (mode_reg == MODE_CLEAR)
                begin
                    clr_addr_next = '0;
                    state_next    = S_CLEAR;
                end
                else if (mode_reg == MODE_READ || mode_reg == MODE_WRITE)
                begin
                    if (over_cap)
                    begin
                        res_next.read_value = (mode_reg == MODE_READ) ? BAD_READ : 64'd0;
                        res_next.status     = ST_CAP;
                        state_next          = S_DONE;
                    end
                    else if (mode_reg == MODE_READ && over_count)
                    begin
                        res_next.read_value = BAD_READ;
                        res_next.status     = ST_COUNT;
                        state_next          = S_DONE;
                    end
                    else
                    begin
                        if (mode_reg == MODE_WRITE && over_count)
                            count_next = CW'(idx_reg + 32'd1);
                        mem_re     = 1'b1;
                        state_next = S_WORD0;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WORD0:
            begin
                mem_we = (mode_reg == MODE_WRITE);
                if (straddle)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = word_idx_hi;
                    state_next = S_WORD1;
                end
                else
                begin
                    res_next.read_value = (mode_reg == MODE_READ) ? elem_read : 64'd0;
                    state_next          = S_DONE;
                end
            end
            S_WORD1:
            begin
                mem_we              = (mode_reg == MODE_WRITE);
                mem_waddr           = word_idx_hi;
                mem_wdata           = merged[127:64];
                res_next.read_value = (mode_reg == MODE_READ) ? elem_read : 64'd0;
                state_next          = S_DONE;
            end
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = 64'd0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(STORE_WORDS - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Item payload and word holding
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= item_mode;
            idx_reg  <= item_index;
            val_reg  <= item_value;
            w_reg    <= elem_width;
            pos_reg  <= {7'd0, item_index} * {32'd0, elem_width};
        end
        if (state_reg == S_WORD0)
            w0_reg <= rdata_reg;
        res_reg <= res_next;
    end

    // Packed word memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

endmodule

`default_nettype wire

/* sv/bpa_out_reg.sv */
// ----------------------------------------------------------------------------
// bpa_out_reg
// Output register between the store and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_out_reg (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   res_valid,
    output logic                        res_ready,
    input  wire bpa_pkg::bpa_result_t   res,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [63:0]                 read_value,
    output logic [1:0]                  status
);
    import bpa_pkg::*;

    logic        valid_reg;
    bpa_result_t data_reg;

    // Take a new result when the slot is empty or drains this cycle
    assign res_ready  = !valid_reg || !out_stall;
    assign out_valid  = valid_reg;
    assign read_value = data_reg.read_value;
    assign status     = data_reg.status;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (res_ready)
            valid_reg <= res_valid;
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            data_reg <= res;
    end

endmodule

`default_nettype wire

/* sv/bpa_checker.sv */
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the bit-packed array store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] index,
    input  wire logic [63:0] value,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [63:0] read_value,
    input  wire logic [1:0]  status
);
    import bpa_pkg::*;

    // Hold a stalled input item
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(mode) && $stable(index)
                                 && $stable(value))
        else $error("stalled input item changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status))
        else $error("stalled result changed");

    // Never report an unknown status
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_CAP)
        else $error("undefined status code");

    // A count miss is always a failed read
    a_count_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_COUNT |-> read_value == BAD_READ)
        else $error("count miss without marker");

    // One item at a time: stall right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

endmodule

bind bit_packed_array_store_core bpa_checker u_bpa_checker (.*);

`default_nettype wire
